@@ src/polynomial_add_multiply_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the polynomial add/multiply block
// Shared wrappers that keep the clocking and reset gating in one place.
// ---------------------------------------------------------------------------
`ifndef POLYNOMIAL_ADD_MULTIPLY_MACROS_SVH
`define POLYNOMIAL_ADD_MULTIPLY_MACROS_SVH

// Checked on every rising edge outside reset
`define PAM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included
`define PAM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/pam_pkg.sv @@
// ---------------------------------------------------------------------------
// pam_pkg
// Types and fixed widths shared by the polynomial add/multiply modules.
// ---------------------------------------------------------------------------
package pam_pkg;

    // Field widths
    localparam int REQ_W  = 2;
    localparam int DEG_W  = 4;
    localparam int COEF_W = 16;
    localparam int MUL_W  = 2 * COEF_W;
    localparam int EXP_W  = 5;
    localparam int PROD_W = 36;
    localparam int SUM_W  = 17;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOAD_FIRST  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_SECOND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RUN         = 2'd2;

    // Register index (paddr bit 2)
    localparam logic REG_DEGREE_FIRST  = 1'b0;
    localparam logic REG_DEGREE_SECOND = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_MAC,
        ST_WAIT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic             wr_first;
        logic             wr_second;
        logic             sum;
        logic             mac;
        logic             mac_end;
        logic [DEG_W-1:0] addr_a;
        logic [DEG_W-1:0] addr_b;
        logic [EXP_W-1:0] term_exp;
        logic             a_en;
        logic             b_en;
        logic             sum_valid;
        logic             last;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_taken;
    } status_t;

endpackage

@@ src/polynomial_add_multiply.sv @@
// ---------------------------------------------------------------------------
// polynomial_add_multiply
// Loads two integer polynomials and emits product and sum terms per exponent.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Payload
//  in       input      in_valid / in_stall       req_type, coef_exponent, coef_value
//  out      output     out_valid / out_stall     exponent, product_coef, sum_coef,
//                                                sum_valid, last
//  cfg      input      APB psel/penable/pwrite   degree_first, degree_second
//
// A load transaction leaves the block idle for the next request. A run
// performs one multiply-accumulate per cycle over the single read port of
// each coefficient RAM, plus a sum read and pipeline drain per result term.
// in_stall stays high from the run transaction until the last term is taken.
// Stalls on out hold the current term and pause the sequencer.
// Reset (rst_n low, asynchronous) clears the degrees and the sequencer.
// ---------------------------------------------------------------------------
module polynomial_add_multiply #(
    parameter int MAX_DEGREE = 15
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pam_pkg::ADDR_W-1:0]         paddr,
    input  logic [pam_pkg::DATA_W-1:0]         pwdata,
    output logic [pam_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    // Input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [pam_pkg::REQ_W-1:0]          req_type,
    input  logic [pam_pkg::DEG_W-1:0]          coef_exponent,
    input  logic signed [pam_pkg::COEF_W-1:0]  coef_value,
    // Output channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [pam_pkg::EXP_W-1:0]          exponent,
    output logic signed [pam_pkg::PROD_W-1:0]  product_coef,
    output logic signed [pam_pkg::SUM_W-1:0]   sum_coef,
    output logic                               sum_valid,
    output logic                               last
);

    logic [pam_pkg::DEG_W-1:0] deg_first_reg, deg_second_reg;
    logic                      cfg_wr;
    logic                      reg_sel;
    pam_pkg::cmd_t             cmd;
    pam_pkg::status_t          status;

    // Register file
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg_first_reg  <= '0;
            deg_second_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                pam_pkg::REG_DEGREE_FIRST:  deg_first_reg  <= pwdata[pam_pkg::DEG_W-1:0];
                pam_pkg::REG_DEGREE_SECOND: deg_second_reg <= pwdata[pam_pkg::DEG_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_sel)
            pam_pkg::REG_DEGREE_FIRST:  prdata = pam_pkg::DATA_W'(deg_first_reg);
            pam_pkg::REG_DEGREE_SECOND: prdata = pam_pkg::DATA_W'(deg_second_reg);
            default:                    prdata = '0;
        endcase
    end

    pam_ctrl #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .deg_first  (deg_first_reg),
        .deg_second (deg_second_reg),
        .status     (status),
        .cmd        (cmd)
    );

    pam_datapath #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .coef_exponent (coef_exponent),
        .coef_value    (coef_value),
        .exponent      (exponent),
        .product_coef  (product_coef),
        .sum_coef      (sum_coef),
        .sum_valid     (sum_valid),
        .last          (last),
        .out_valid     (out_valid),
        .out_stall     (out_stall)
    );

endmodule

@@ src/pam_ram.sv @@
// ---------------------------------------------------------------------------
// pam_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module pam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/pam_ctrl.sv @@
// ---------------------------------------------------------------------------
// pam_ctrl
// Sequencer: decodes requests, walks exponents and coefficient pairs.
// ---------------------------------------------------------------------------
module pam_ctrl #(
    parameter int MAX_DEGREE = 15
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [pam_pkg::REQ_W-1:0]  req_type,
    input  logic [pam_pkg::DEG_W-1:0]  deg_first,
    input  logic [pam_pkg::DEG_W-1:0]  deg_second,
    input  pam_pkg::status_t           status,
    output pam_pkg::cmd_t              cmd
);

    pam_pkg::state_t              state_reg, state_next;
    logic [pam_pkg::EXP_W-1:0]    k_reg, k_next;
    logic [pam_pkg::DEG_W-1:0]    i_reg, i_next;

    logic [pam_pkg::DEG_W-1:0]    n, m;
    logic [pam_pkg::EXP_W-1:0]    n_x, m_x, dmax_x, total;
    logic [pam_pkg::EXP_W-1:0]    i_lo_x, j_x;
    logic [pam_pkg::DEG_W-1:0]    i_lo, i_hi;

    // Degrees clamped to the store size
    assign n = (int'(deg_first) > MAX_DEGREE) ? pam_pkg::DEG_W'(MAX_DEGREE) : deg_first;
    assign m = (int'(deg_second) > MAX_DEGREE) ? pam_pkg::DEG_W'(MAX_DEGREE) : deg_second;
    assign n_x    = pam_pkg::EXP_W'(n);
    assign m_x    = pam_pkg::EXP_W'(m);
    assign dmax_x = (n_x > m_x) ? n_x : m_x;
    assign total  = n_x + m_x;

    // Pair range for exponent k: i from max(0, k-m) to min(n, k), j = k - i
    assign i_lo_x = (k_reg > m_x) ? (k_reg - m_x) : '0;
    assign i_lo   = i_lo_x[pam_pkg::DEG_W-1:0];
    assign i_hi   = (k_reg > n_x) ? n : k_reg[pam_pkg::DEG_W-1:0];
    assign j_x    = k_reg - pam_pkg::EXP_W'(i_reg);

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pam_pkg::ST_IDLE;
            k_reg     <= '0;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        cmd        = '0;
        in_stall   = 1'b1;

        unique case (state_reg)
            pam_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    unique case (req_type)
                        pam_pkg::REQ_LOAD_FIRST:  cmd.wr_first  = 1'b1;
                        pam_pkg::REQ_LOAD_SECOND: cmd.wr_second = 1'b1;
                        pam_pkg::REQ_RUN:
                        begin
                            k_next     = total;
                            state_next = pam_pkg::ST_SUM;
                        end
                        default: ;
                    endcase
                end
            end

            pam_pkg::ST_SUM:
            begin
                // Read both coefficients at k for the sum term
                cmd.sum       = 1'b1;
                cmd.addr_a    = k_reg[pam_pkg::DEG_W-1:0];
                cmd.addr_b    = k_reg[pam_pkg::DEG_W-1:0];
                cmd.term_exp  = k_reg;
                cmd.a_en      = (k_reg <= n_x);
                cmd.b_en      = (k_reg <= m_x);
                cmd.sum_valid = (k_reg <= dmax_x);
                cmd.last      = (k_reg == '0);
                i_next        = i_lo;
                state_next    = pam_pkg::ST_MAC;
            end

            pam_pkg::ST_MAC:
            begin
                cmd.mac     = 1'b1;
                cmd.addr_a  = i_reg;
                cmd.addr_b  = j_x[pam_pkg::DEG_W-1:0];
                cmd.mac_end = (i_reg == i_hi);
                if (i_reg == i_hi)
                begin
                    state_next = pam_pkg::ST_WAIT;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end

            pam_pkg::ST_WAIT:
            begin
                if (status.out_taken)
                begin
                    if (k_reg == '0)
                    begin
                        state_next = pam_pkg::ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg - 1'b1;
                        state_next = pam_pkg::ST_SUM;
                    end
                end
            end

            default: state_next = pam_pkg::ST_IDLE;
        endcase
    end

endmodule

@@ src/pam_datapath.sv @@
// ---------------------------------------------------------------------------
// pam_datapath
// Coefficient RAMs, multiply-accumulate pipeline, sum adder, output register.
// ---------------------------------------------------------------------------
module pam_datapath #(
    parameter int MAX_DEGREE = 15
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pam_pkg::cmd_t                     cmd,
    output pam_pkg::status_t                  status,
    input  logic [pam_pkg::DEG_W-1:0]         coef_exponent,
    input  logic signed [pam_pkg::COEF_W-1:0] coef_value,
    output logic [pam_pkg::EXP_W-1:0]         exponent,
    output logic signed [pam_pkg::PROD_W-1:0] product_coef,
    output logic signed [pam_pkg::SUM_W-1:0]  sum_coef,
    output logic                              sum_valid,
    output logic                              last,
    output logic                              out_valid,
    input  logic                              out_stall
);

    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int AW    = $clog2(DEPTH);

    logic                              exp_ok;
    logic [AW-1:0]                     waddr;
    logic [pam_pkg::COEF_W-1:0]        rdata_a, rdata_b;
    logic signed [pam_pkg::COEF_W-1:0] a_val, b_val;

    // Pipeline control
    logic p1_sum_reg, p1_mac_reg, p1_end_reg;
    logic p2_mac_reg, p2_end_reg;
    logic out_valid_reg;
    logic out_taken;

    // Payload
    logic [pam_pkg::EXP_W-1:0]         term_exp_reg;
    logic                              term_a_en_reg, term_b_en_reg;
    logic                              term_sv_reg, term_last_reg;
    logic signed [pam_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic signed [pam_pkg::MUL_W-1:0]  prod_reg, prod_next;
    logic signed [pam_pkg::PROD_W-1:0] acc_reg, acc_next;
    logic signed [pam_pkg::PROD_W-1:0] out_prod_reg;

    // Load decode: exponents past the store are dropped
    assign exp_ok = (int'(coef_exponent) <= MAX_DEGREE);
    assign waddr  = AW'(coef_exponent);

    pam_ram #(
        .WIDTH (pam_pkg::COEF_W),
        .DEPTH (DEPTH)
    ) u_ram_first (
        .clk   (clk),
        .we    (cmd.wr_first & exp_ok),
        .waddr (waddr),
        .wdata (coef_value),
        .raddr (AW'(cmd.addr_a)),
        .rdata (rdata_a)
    );

    pam_ram #(
        .WIDTH (pam_pkg::COEF_W),
        .DEPTH (DEPTH)
    ) u_ram_second (
        .clk   (clk),
        .we    (cmd.wr_second & exp_ok),
        .waddr (waddr),
        .wdata (coef_value),
        .raddr (AW'(cmd.addr_b)),
        .rdata (rdata_b)
    );

    assign a_val = rdata_a;
    assign b_val = rdata_b;

    // Stage 1 arithmetic: product and gated sum
    assign prod_next = pam_pkg::MUL_W'(a_val) * pam_pkg::MUL_W'(b_val);
    assign sum_next  = (term_a_en_reg ? pam_pkg::SUM_W'(a_val) : '0)
                     + (term_b_en_reg ? pam_pkg::SUM_W'(b_val) : '0);

    // Stage 2 accumulate
    assign acc_next  = acc_reg + pam_pkg::PROD_W'(prod_reg);

    assign out_taken = out_valid_reg & ~out_stall;

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_sum_reg    <= 1'b0;
            p1_mac_reg    <= 1'b0;
            p1_end_reg    <= 1'b0;
            p2_mac_reg    <= 1'b0;
            p2_end_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p1_sum_reg <= cmd.sum;
            p1_mac_reg <= cmd.mac;
            p1_end_reg <= cmd.mac & cmd.mac_end;
            p2_mac_reg <= p1_mac_reg;
            p2_end_reg <= p1_end_reg;
            if (p2_end_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_taken)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Term info, sum, product and accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            term_exp_reg  <= cmd.term_exp;
            term_a_en_reg <= cmd.a_en;
            term_b_en_reg <= cmd.b_en;
            term_sv_reg   <= cmd.sum_valid;
            term_last_reg <= cmd.last;
        end
        if (p1_sum_reg)
        begin
            sum_reg <= sum_next;
        end
        if (p1_mac_reg)
        begin
            prod_reg <= prod_next;
        end
        // Sum step opens a term: clear the accumulator
        if (p1_sum_reg)
        begin
            acc_reg <= '0;
        end
        else if (p2_mac_reg)
        begin
            acc_reg <= acc_next;
        end
        if (p2_end_reg)
        begin
            out_prod_reg <= acc_next;
        end
    end

    // Outputs: term registers hold until the next term starts
    assign out_valid        = out_valid_reg;
    assign exponent         = term_exp_reg;
    assign product_coef     = out_prod_reg;
    assign sum_coef         = sum_reg;
    assign sum_valid        = term_sv_reg;
    assign last             = term_last_reg;
    assign status.out_taken = out_taken;

endmodule

@@ src/pam_checker.sv @@
// ---------------------------------------------------------------------------
// pam_checker
// Port-level checks on result ordering and output behavior.
// ---------------------------------------------------------------------------
`include "polynomial_add_multiply_macros.svh"

module pam_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic [pam_pkg::EXP_W-1:0]          exponent,
    input logic signed [pam_pkg::PROD_W-1:0]  product_coef,
    input logic signed [pam_pkg::SUM_W-1:0]   sum_coef,
    input logic                               sum_valid,
    input logic                               last
);

    // No result in the cycle after reset has been seen
    `PAM_ASSERT_RST(a_no_out_in_reset, !rst_n |=> !out_valid, "out_valid after reset")

    // Sum is zero above the larger degree
    `PAM_ASSERT(a_sum_zero, (out_valid && !sum_valid) |-> (sum_coef == '0), "sum_coef not zero")

    // Last marks exponent zero and nothing else
    `PAM_ASSERT(a_last_exp, out_valid |-> (last == (exponent == '0)), "last and exponent disagree")

    // A run still in progress keeps the input closed
    `PAM_ASSERT(a_run_busy, (out_valid && !out_stall && !last) |=> in_stall, "input open mid-run")

    // A stalled result holds
    `PAM_ASSERT(a_out_hold,
        (out_valid && out_stall) |=>
        (out_valid && $stable(exponent) && $stable(product_coef)),
        "stalled result changed")

endmodule

bind polynomial_add_multiply pam_checker u_pam_checker (.*);

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for polynomial_add_multiply
// Loads coefficient pairs, fires run transactions at a range of degree
// settings and checks every emitted term (exponent, product, sum, flags)
// against a convolution predictor or directed values. Both channels see random gaps.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Request code the block drops without a result
    localparam logic [pam_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam int NUM_COEFS     = 16;
    localparam int NUM_TERMS     = 2 * NUM_COEFS - 1;
    localparam int ITEMS_PER_SET = 35;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 50;

    // One expected output term
    typedef struct packed {
        logic [pam_pkg::EXP_W-1:0]         term_exp;
        logic signed [pam_pkg::PROD_W-1:0] term_prod;
        logic signed [pam_pkg::SUM_W-1:0]  term_sum;
        logic                              term_sum_ok;
        logic                              term_last;
    } term_t;

    // One row of the directed stimulus
    typedef struct packed {
        logic [pam_pkg::REQ_W-1:0]         req;
        logic [pam_pkg::DEG_W-1:0]         expo;
        logic signed [pam_pkg::COEF_W-1:0] value;
        logic                              typed;
        logic signed [pam_pkg::PROD_W-1:0] prod;
        logic signed [pam_pkg::SUM_W-1:0]  sum;
    } stim_row_t;

    logic                              clk           = 1'b0;
    logic                              rst_n         = 1'b0;
    logic                              psel          = 1'b0;
    logic                              penable       = 1'b0;
    logic                              pwrite        = 1'b0;
    logic [pam_pkg::ADDR_W-1:0]        paddr         = '0;
    logic [pam_pkg::DATA_W-1:0]        pwdata        = '0;
    logic [pam_pkg::DATA_W-1:0]        prdata;
    logic                              pready;
    logic                              in_valid      = 1'b0;
    logic                              in_stall;
    logic [pam_pkg::REQ_W-1:0]         req_type      = pam_pkg::REQ_LOAD_FIRST;
    logic [pam_pkg::DEG_W-1:0]         coef_exponent = '0;
    logic signed [pam_pkg::COEF_W-1:0] coef_value    = '0;
    logic                              out_valid;
    logic                              out_stall     = 1'b0;
    logic [pam_pkg::EXP_W-1:0]         exponent;
    logic signed [pam_pkg::PROD_W-1:0] product_coef;
    logic signed [pam_pkg::SUM_W-1:0]  sum_coef;
    logic                              sum_valid;
    logic                              last;

    // Predictor state: coefficient stores, degrees, written flags
    logic signed [pam_pkg::COEF_W-1:0] first_coefs  [NUM_COEFS];
    logic signed [pam_pkg::COEF_W-1:0] second_coefs [NUM_COEFS];
    bit                                first_written  [NUM_COEFS];
    bit                                second_written [NUM_COEFS];
    logic [pam_pkg::DEG_W-1:0]         deg_first  = '0;
    logic [pam_pkg::DEG_W-1:0]         deg_second = '0;

    term_t     term_q [$];
    stim_row_t stim_rows [$];

    int mismatches    = 0;
    int terms_checked = 0;
    int loads_sent    = 0;
    int runs_sent     = 0;
    int ignored_sent  = 0;
    int settings_used = 0;

    polynomial_add_multiply i_dut (.*);

    // Clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("TIMEOUT: %0d terms still expected", term_q.size());
        $display("polynomial_add_multiply test failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Convolution and sum of the two stored polynomials, highest exponent first
    function automatic void predict_run();
        longint acc [NUM_TERMS];
        longint s;
        int     n;
        int     m;
        int     dmax;
        int     i;
        int     j;
        int     k;
        term_t  t;
        // 4-bit degrees can never exceed the store depth, no clamp needed
        n    = deg_first;
        m    = deg_second;
        dmax = (n > m) ? n : m;
        for (k = 0; k < NUM_TERMS; k++)
            acc[k] = 0;
        for (i = 0; i <= n; i++)
            for (j = 0; j <= m; j++)
                acc[i + j] += longint'(first_coefs[i]) * longint'(second_coefs[j]);
        for (k = n + m; k >= 0; k--)
        begin
            s = 0;
            if (k <= dmax)
            begin
                if (k <= n)
                    s += longint'(first_coefs[k]);
                if (k <= m)
                    s += longint'(second_coefs[k]);
            end
            t.term_exp    = k[pam_pkg::EXP_W-1:0];
            t.term_prod   = acc[k][pam_pkg::PROD_W-1:0];
            t.term_sum    = s[pam_pkg::SUM_W-1:0];
            t.term_sum_ok = (k <= dmax);
            t.term_last   = (k == 0);
            term_q.push_back(t);
        end
    endfunction

    // Update the predictor for one accepted transaction
    function automatic void accept_item(input logic [pam_pkg::REQ_W-1:0] r,
                                        input logic [pam_pkg::DEG_W-1:0] e,
                                        input logic signed [pam_pkg::COEF_W-1:0] v,
                                        input bit predicted);
        case (r)
            pam_pkg::REQ_LOAD_FIRST:
            begin
                first_coefs[e]   = v;
                first_written[e] = 1'b1;
                loads_sent++;
            end
            pam_pkg::REQ_LOAD_SECOND:
            begin
                second_coefs[e]   = v;
                second_written[e] = 1'b1;
                loads_sent++;
            end
            pam_pkg::REQ_RUN:
            begin
                runs_sent++;
                if (predicted)
                    predict_run();
            end
            default:
                ignored_sent++;
        endcase
    endfunction

    // Drive one transaction and hold it until accepted
    task automatic send_item(input logic [pam_pkg::REQ_W-1:0] r,
                             input logic [pam_pkg::DEG_W-1:0] e,
                             input logic signed [pam_pkg::COEF_W-1:0] v,
                             input bit predicted);
        @(negedge clk);
        in_valid      <= 1'b1;
        req_type      <= r;
        coef_exponent <= e;
        coef_value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        accept_item(r, e, v, predicted);
    endtask

    // Drop valid for the requested gap, with junk on the payload; nothing when n is zero
    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            in_valid      <= 1'b0;
            req_type      <= pam_pkg::REQ_W'($urandom);
            coef_exponent <= pam_pkg::DEG_W'($urandom);
            coef_value    <= pam_pkg::COEF_W'($urandom);
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Stop sending, wait for every expected term, then let the block settle
    task automatic drain_terms(input int settle);
        @(negedge clk);
        in_valid <= 1'b0;
        while (term_q.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // APB write of a degree register, followed by a read-back check
    task automatic program_degree(input logic sel, input logic [pam_pkg::DEG_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {{(pam_pkg::DATA_W-pam_pkg::DEG_W){1'b0}}, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (sel == pam_pkg::REG_DEGREE_FIRST)
            deg_first = value;
        else
            deg_second = value;
        // read back
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {{(pam_pkg::DATA_W-pam_pkg::DEG_W){1'b0}}, value})
            report_mismatch("register read-back", longint'(prdata), longint'(value));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic signed [pam_pkg::COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 7))
            0:       return {1'b1, {(pam_pkg::COEF_W-1){1'b0}}};
            1:       return {1'b0, {(pam_pkg::COEF_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return pam_pkg::COEF_W'($urandom);
        endcase
    endfunction

    function automatic int sender_gap(input bit quiet);
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random transaction: mostly loads into the live range and runs once every
    // coefficient they read has been written; some dropped requests as noise
    function automatic void pick_item(output logic [pam_pkg::REQ_W-1:0] r,
                                      output logic [pam_pkg::DEG_W-1:0] e,
                                      output logic signed [pam_pkg::COEF_W-1:0] v);
        int roll;
        int miss_sel;
        int miss_e;
        int i;
        int top;
        roll     = $urandom_range(0, 99);
        miss_sel = -1;
        miss_e   = 0;
        for (i = 0; i <= deg_first; i++)
            if (!first_written[i] && miss_sel < 0)
            begin
                miss_sel = 0;
                miss_e   = i;
            end
        for (i = 0; i <= deg_second; i++)
            if (!second_written[i] && miss_sel < 0)
            begin
                miss_sel = 1;
                miss_e   = i;
            end
        v = rand_coef();
        if (roll < 6)
        begin
            r = REQ_UNUSED;
            e = pam_pkg::DEG_W'($urandom);
        end
        else if ((roll < 24 && miss_sel < 0))
        begin
            r = pam_pkg::REQ_RUN;
            e = pam_pkg::DEG_W'($urandom);
        end
        else if (miss_sel >= 0 && (roll < 24 || $urandom_range(0, 1) == 1))
        begin
            r = (miss_sel == 0) ? pam_pkg::REQ_LOAD_FIRST : pam_pkg::REQ_LOAD_SECOND;
            e = miss_e[pam_pkg::DEG_W-1:0];
        end
        else
        begin
            r   = ($urandom_range(0, 1) == 0) ? pam_pkg::REQ_LOAD_FIRST
                                              : pam_pkg::REQ_LOAD_SECOND;
            top = (r == pam_pkg::REQ_LOAD_FIRST) ? deg_first : deg_second;
            if ($urandom_range(0, 4) == 0)
                e = pam_pkg::DEG_W'($urandom);
            else
                e = pam_pkg::DEG_W'($urandom_range(0, top));
        end
    endfunction

    function automatic void add_row(input logic [pam_pkg::REQ_W-1:0] r,
                                    input logic [pam_pkg::DEG_W-1:0] e,
                                    input logic signed [pam_pkg::COEF_W-1:0] v,
                                    input bit typed,
                                    input longint prod, input longint sum);
        stim_row_t row;
        row.req   = r;
        row.expo  = e;
        row.value = v;
        row.typed = typed;
        row.prod  = prod[pam_pkg::PROD_W-1:0];
        row.sum   = sum[pam_pkg::SUM_W-1:0];
        stim_rows.push_back(row);
    endfunction

    // Output side: random stalls in bursts, with quiet stretches
    int unsigned stall_left = 0;
    int unsigned mode_left  = 0;
    bit          out_quiet  = 1'b0;

    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            out_quiet = ($urandom_range(0, 3) == 0);
            mode_left = $urandom_range(50, 300);
        end
        else
            mode_left--;
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!out_quiet && $urandom_range(0, 4) == 0)
        begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 2);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Output checker
    always @(posedge clk)
    begin : term_check
        term_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (term_q.size() == 0)
                report_mismatch("term with nothing expected, exponent", exponent, -1);
            else
            begin
                want = term_q.pop_front();
                terms_checked++;
                if (exponent !== want.term_exp)
                    report_mismatch("exponent", exponent, want.term_exp);
                if (product_coef !== want.term_prod)
                    report_mismatch("product_coef", product_coef, want.term_prod);
                if (sum_coef !== want.term_sum)
                    report_mismatch("sum_coef", sum_coef, want.term_sum);
                if (sum_valid !== want.term_sum_ok)
                    report_mismatch("sum_valid", sum_valid, want.term_sum_ok);
                if (last !== want.term_last)
                    report_mismatch("last", last, want.term_last);
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        stim_row_t                         row;
        term_t                             t;
        logic [pam_pkg::REQ_W-1:0]         r;
        logic [pam_pkg::DEG_W-1:0]         e;
        logic signed [pam_pkg::COEF_W-1:0] v;
        logic [pam_pkg::DEG_W-1:0]         set_first  [7];
        logic [pam_pkg::DEG_W-1:0]         set_second [7];
        bit                                quiet;
        int                                s;
        int                                n;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, degrees at their reset value of zero
        add_row(pam_pkg::REQ_LOAD_FIRST,  4'd0,  16'sh8000, 1'b0, 0, 0);
        add_row(pam_pkg::REQ_LOAD_SECOND, 4'd0,  16'sh8000, 1'b0, 0, 0);
        add_row(pam_pkg::REQ_RUN,         4'd0,  16'sd0,    1'b1, 64'sd1073741824, -65536);
        add_row(pam_pkg::REQ_LOAD_FIRST,  4'd0,  16'sh7fff, 1'b0, 0, 0);
        add_row(pam_pkg::REQ_LOAD_SECOND, 4'd0,  16'sh7fff, 1'b0, 0, 0);
        add_row(pam_pkg::REQ_RUN,         4'd0,  16'sh7fff, 1'b1, 64'sd1073676289, 65534);
        add_row(pam_pkg::REQ_LOAD_FIRST,  4'd0,  16'sh8000, 1'b0, 0, 0);
        add_row(pam_pkg::REQ_RUN,         4'd0,  16'sd0,    1'b1, -64'sd1073709056, -1);
        // dropped request, then loads above the live degree
        add_row(REQ_UNUSED,               4'd15, -16'sd1,   1'b0, 0, 0);
        add_row(pam_pkg::REQ_LOAD_FIRST,  4'd15, 16'sh5555, 1'b0, 0, 0);
        add_row(pam_pkg::REQ_LOAD_SECOND, 4'd15, 16'shaaaa, 1'b0, 0, 0);
        add_row(pam_pkg::REQ_RUN,         4'd15, -16'sd1,   1'b1, -64'sd1073709056, -1);
        add_row(pam_pkg::REQ_LOAD_SECOND, 4'd0,  16'sd0,    1'b0, 0, 0);
        add_row(pam_pkg::REQ_RUN,         4'd0,  16'sd0,    1'b1, 0, -32768);
        add_row(pam_pkg::REQ_LOAD_FIRST,  4'd7,  16'sh1234, 1'b0, 0, 0);
        add_row(pam_pkg::REQ_RUN,         4'd0,  16'sd0,    1'b0, 0, 0);

        foreach (stim_rows[i])
        begin
            row = stim_rows[i];
            idle_cycles(sender_gap(1'b0));
            send_item(row.req, row.expo, row.value, !row.typed);
            if (row.typed)
            begin
                t.term_exp    = '0;
                t.term_prod   = row.prod;
                t.term_sum    = row.sum;
                t.term_sum_ok = 1'b1;
                t.term_last   = 1'b1;
                term_q.push_back(t);
            end
        end
        drain_terms(SETTLE_CYCLES);

        // Degree settings: extremes, small, then two random
        set_first[0] = 4'd15; set_second[0] = 4'd15;
        set_first[1] = 4'd15; set_second[1] = 4'd0;
        set_first[2] = 4'd0;  set_second[2] = 4'd15;
        set_first[3] = 4'd1;  set_second[3] = 4'd1;
        set_first[4] = 4'd3;  set_second[4] = 4'd7;
        set_first[5] = pam_pkg::DEG_W'($urandom); set_second[5] = pam_pkg::DEG_W'($urandom);
        set_first[6] = pam_pkg::DEG_W'($urandom); set_second[6] = pam_pkg::DEG_W'($urandom);

        for (s = 0; s < 7; s++)
        begin
            program_degree(pam_pkg::REG_DEGREE_FIRST, set_first[s]);
            program_degree(pam_pkg::REG_DEGREE_SECOND, set_second[s]);
            settings_used++;
            quiet = ($urandom_range(0, 3) == 0);
            for (n = 0; n < ITEMS_PER_SET; n++)
            begin
                // sender holds off until the block has emitted everything
                if (n == ITEMS_PER_SET / 2)
                    drain_terms(0);
                idle_cycles(sender_gap(quiet));
                pick_item(r, e, v);
                send_item(r, e, v, 1'b1);
            end
            drain_terms(SETTLE_CYCLES);
        end

        drain_terms(TAIL_CYCLES);

        $display("Covered %0d loads, %0d runs and %0d dropped requests over %0d degree settings",
                 loads_sent, runs_sent, ignored_sent, settings_used + 1);
        $display("Checked %0d output terms, %0d mismatches", terms_checked, mismatches);
        if (mismatches == 0 && term_q.size() == 0)
            $display("polynomial_add_multiply test passed");
        else
            $display("polynomial_add_multiply test failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/pam_pkg.sv
src/pam_ram.sv
src/pam_ctrl.sv
src/pam_datapath.sv
src/polynomial_add_multiply.sv
src/pam_checker.sv
sim/tb_top.sv
